// ===== rtl/core/ascending_integer_sorter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ascending integer sorter
// Shared property forms for the clocked checks of the sorter.
// ----------------------------------------------------------------------------
`ifndef ASCENDING_INTEGER_SORTER_UNIT_MACROS_SVH
`define ASCENDING_INTEGER_SORTER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define AIS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define AIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ais_pkg.sv =====
// ----------------------------------------------------------------------------
// Ascending integer sorter package
// Types and codes shared by the sorter cells and the top level.
// ----------------------------------------------------------------------------
package ais_pkg;

  // Width of one held value.
  localparam int VALUE_W = 32;

  // Operation codes of an input transaction.
  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_DRAIN  = 1'b1
  } func_t;

  // Status codes of a result transaction.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;  // insert the broadcast value, shift larger values up
    logic drn;  // shift every value one cell down toward cell 0
  } cell_ctrl_t;

endpackage

// ===== rtl/core/ais_cell.sv =====
// ----------------------------------------------------------------------------
// Sorter cell
// Holds one value of the ascending chain. On insert it keeps its value, takes
// the new value or takes its lower neighbor's value; on drain it takes its
// upper neighbor's value.
// ----------------------------------------------------------------------------
module ais_cell
  import ais_pkg::*;
(
  input  logic                      clk,
  input  cell_ctrl_t                ctrl,
  input  logic signed [VALUE_W-1:0] ins_value,
  input  logic                      occ,
  input  logic                      prev_take,
  input  logic signed [VALUE_W-1:0] prev_value,
  input  logic signed [VALUE_W-1:0] next_value,
  output logic signed [VALUE_W-1:0] value,
  output logic                      take
);

  logic signed [VALUE_W-1:0] value_r;
  logic signed [VALUE_W-1:0] value_nxt;

  // An empty cell acts as plus infinity, so the new value lands there at the latest.
  assign take = !occ || (ins_value < value_r);

  // Choose the next held value from the command and the neighbor decision.
  always_comb begin
    value_nxt = value_r;
    if (ctrl.ins) begin
      if (prev_take) begin
        value_nxt = prev_value;
      end else if (take) begin
        value_nxt = ins_value;
      end
    end else if (ctrl.drn) begin
      value_nxt = next_value;
    end
  end

  // Value register; its contents only matter while the cell is occupied.
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

// ===== rtl/core/ascending_integer_sorter_unit.sv =====
// ----------------------------------------------------------------------------
// Ascending integer sorter unit
// A drain result is registered, valid in the cycle after its input is taken.
// Throughput: one insert or drain per cycle while no result waits; every cell
// of the chain updates in the same cycle from its own compare and neighbors' values.
// Reset: clears the held count and the output valid; cell values stay as is.
// ----------------------------------------------------------------------------
`include "ascending_integer_sorter_unit_macros.svh"

module ascending_integer_sorter_unit
  import ais_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_func,
  input  logic signed [VALUE_W-1:0] in_value_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] out_value_out,
  output logic                      out_last,
  output logic [1:0]                out_status
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic signed [VALUE_W-1:0] out_value_r;
  logic signed [VALUE_W-1:0] out_value_nxt;
  logic                      out_last_r;
  logic                      out_last_nxt;
  status_t                   out_status_r;
  status_t                   out_status_nxt;

  logic                      in_accept;
  logic                      is_drain;
  logic                      full;
  logic                      empty;
  logic                      produce;
  cell_ctrl_t                ctrl;

  logic signed [VALUE_W-1:0] cell_value [DEPTH];
  logic                      cell_take  [DEPTH];

  // Input handshake and command decode.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign is_drain  = (in_func == FUNC_DRAIN);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign ctrl.ins  = in_accept && !is_drain && !full;
  assign ctrl.drn  = in_accept && is_drain && !empty;
  assign produce   = in_accept && (is_drain || full);

  // Chain of cells, smallest value in cell 0.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      occ;
    logic                      prev_take;
    logic signed [VALUE_W-1:0] prev_value;
    logic signed [VALUE_W-1:0] next_value;

    assign occ = (count_r > CNT_W'(i));

    if (i == 0) begin : g_first
      assign prev_take  = 1'b0;
      assign prev_value = '0;
    end else begin : g_inner
      assign prev_take  = cell_take[i-1];
      assign prev_value = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_value = '0;
    end else begin : g_below
      assign next_value = cell_value[i+1];
    end

    ais_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .ins_value  (in_value_in),
      .occ        (occ),
      .prev_take  (prev_take),
      .prev_value (prev_value),
      .next_value (next_value),
      .value      (cell_value[i]),
      .take       (cell_take[i])
    );
  end

  // Held count follows successful inserts and drains.
  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.drn) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Result register: loaded by a drain or a rejected insert, freed when taken.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    if (produce) begin
      out_valid_nxt = 1'b1;
      priority if (!is_drain) begin
        out_value_nxt  = '0;
        out_last_nxt   = 1'b0;
        out_status_nxt = ST_FULL;
      end else if (empty) begin
        out_value_nxt  = '0;
        out_last_nxt   = 1'b0;
        out_status_nxt = ST_EMPTY;
      end else begin
        out_value_nxt  = cell_value[0];
        out_last_nxt   = (count_r == CNT_W'(1));
        out_status_nxt = ST_OK;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_value_out = out_value_r;
  assign out_last      = out_last_r;
  assign out_status    = out_status_r;

  // Checks on the count and the result path.
  `AIS_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "held count exceeds depth")
  `AIS_ASSERT_NEXT(a_insert_count, ctrl.ins,
                   count_r == $past(count_r) + CNT_W'(1), "insert miscounted")
  `AIS_ASSERT_NEXT(a_drain_result, ctrl.drn,
                   out_valid_r && out_status_r == ST_OK && out_value_r == $past(cell_value[0]),
                   "drain result wrong")

endmodule
